### hw/rtl/tst_pkg.sv
// Shared types and constants for the timer slot table.
// Used by tst_free_stack and timer_slot_table; depends on nothing else.
package tst_pkg;

    // Input command codes
    localparam logic [1:0] CMD_SCHEDULE   = 2'd0;
    localparam logic [1:0] CMD_CANCEL     = 2'd1;
    localparam logic [1:0] CMD_CANCEL_ALL = 2'd2;
    localparam logic [1:0] CMD_TICK       = 2'd3;

    // Result kind codes
    localparam logic [2:0] KIND_SCHEDULED   = 3'd0;
    localparam logic [2:0] KIND_FULL        = 3'd1;
    localparam logic [2:0] KIND_CANCEL_DONE = 3'd2;
    localparam logic [2:0] KIND_FIRED       = 3'd3;
    localparam logic [2:0] KIND_TICK_DONE   = 3'd4;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FULL,
        ST_IDSCAN,
        ST_COMMIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control from the sequencer to the free-index stack.
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } stk_ctrl_t;

    // One step of the Galois LFSR used for timer ids.
    function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
        logic [15:0] shifted;
        shifted = {1'b0, cur[15:1]};
        return cur[0] ? (shifted ^ LFSR_MASK) : shifted;
    endfunction

endpackage

### hw/rtl/tst_free_stack.sv
// Free-index stack of the timer slot table, held in a memory with a registered read.
// Depends on tst_pkg for the control struct.
module tst_free_stack #(
    parameter int SLOTS = 16,
    localparam int IDXW = $clog2(SLOTS),
    localparam int CNTW = $clog2(SLOTS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tst_pkg::stk_ctrl_t ctrl,
    input  logic [CNTW-1:0]   count,
    input  logic [IDXW-1:0]   push_slot,
    output logic [IDXW-1:0]   top_slot
);
    import tst_pkg::*;

    logic [IDXW-1:0] stk_mem [SLOTS];
    logic [IDXW-1:0] rd_data_reg;
    logic [IDXW-1:0] rd_pos_reg;
    logic [CNTW-1:0] wm_reg;
    logic [CNTW-1:0] wm_next;
    logic [CNTW-1:0] pos;

    assign pos = count - CNTW'(1);

    // Positions below the watermark were never written since reset and
    // still hold their own index.
    assign top_slot = (CNTW'(rd_pos_reg) < wm_reg) ? rd_pos_reg : rd_data_reg;

    always_comb begin
        wm_next = wm_reg;
        if (ctrl.pop && (pos < wm_reg)) begin
            wm_next = pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_reg <= CNTW'(SLOTS);
        end else begin
            wm_reg <= wm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            stk_mem[count[IDXW-1:0]] <= push_slot;
        end
        if (ctrl.rd_en && (count != '0)) begin
            rd_data_reg <= stk_mem[pos[IDXW-1:0]];
            rd_pos_reg  <= pos[IDXW-1:0];
        end
    end

endmodule

### hw/rtl/timer_slot_table.sv
// Timer slot table: one-shot alarms in slot memories, scanned by a small sequencer.
// Depends on tst_pkg and tst_free_stack.
//
//   channel  | ports                                            | direction
//   s_       | s_command s_time_value s_timer_id s_handler_tag  | in,  valid/ready
//   m_       | m_kind m_out_id m_out_tag m_last                 | out, valid/ready
//
// Cancel, cancel-all and tick walk the slots one per cycle through a single
// registered read port, except that a tick holds while a fired result waits on
// m_ready. Schedule walks the stored ids once per id attempt, with at most
// SLOTS + 2 attempts. Reset is synchronous and needs no clearing pass; s_ready is
// low while an item is in work, and a result waiting in the output register
// does not block the next transfer on the input side.
module timer_slot_table #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32,
    parameter int TAG_BITS  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [TIME_BITS-1:0] s_time_value,
    input  logic [15:0]          s_timer_id,
    input  logic [TAG_BITS-1:0]  s_handler_tag,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_kind,
    output logic [15:0]          m_out_id,
    output logic [TAG_BITS-1:0]  m_out_tag,
    output logic                 m_last
);
    import tst_pkg::*;

    localparam int IDXW = $clog2(SLOTS);
    localparam int CNTW = $clog2(SLOTS + 1);
    localparam int TRW  = $clog2(SLOTS + 2);

    state_t state_reg, state_next;

    logic [1:0]           cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [15:0]          tid_reg, tid_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    logic [15:0]     lfsr_reg, lfsr_next;
    logic [TRW-1:0]  tries_reg, tries_next;
    logic [CNTW-1:0] free_cnt_reg, free_cnt_next;
    logic [CNTW-1:0] act_cnt_reg, act_cnt_next;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [SLOTS-1:0] id_vld_reg, id_vld_next;

    // Scan pipeline: rd_idx is the address issued, p_idx the slot whose
    // data sits in the read registers when pv is set.
    logic [CNTW-1:0] rd_idx_reg, rd_idx_next;
    logic [IDXW-1:0] p_idx_reg, p_idx_next;
    logic            pv_reg, pv_next;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_kind_reg, m_kind_next;
    logic [15:0]          m_out_id_reg, m_out_id_next;
    logic [TAG_BITS-1:0]  m_out_tag_reg, m_out_tag_next;
    logic                 m_last_reg, m_last_next;

    logic [15:0]          ident_mem [SLOTS];
    logic [TIME_BITS-1:0] dl_mem [SLOTS];
    logic [TAG_BITS-1:0]  tag_mem [SLOTS];
    logic [15:0]          ident_rd_reg;
    logic [TIME_BITS-1:0] dl_rd_reg;
    logic [TAG_BITS-1:0]  tag_rd_reg;

    logic            rd_en;
    logic            mem_we;
    logic [IDXW-1:0] top_slot;
    stk_ctrl_t       stk_ctrl;

    logic out_free;
    logic p_act;
    logic hit_id;
    logic scan_hit;
    logic scan_end;
    logic table_full;

    tst_free_stack #(
        .SLOTS(SLOTS)
    ) u_free_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (stk_ctrl),
        .count    (free_cnt_reg),
        .push_slot(p_idx_reg),
        .top_slot (top_slot)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_out_id  = m_out_id_reg;
    assign m_out_tag = m_out_tag_reg;
    assign m_last    = m_last_reg;

    assign out_free   = !m_valid_reg || m_ready;
    assign p_act      = active_reg[p_idx_reg];
    assign hit_id     = id_vld_reg[p_idx_reg] && (ident_rd_reg == lfsr_reg);
    assign scan_end   = !pv_reg && (rd_idx_reg == CNTW'(SLOTS));
    assign table_full = (free_cnt_reg == '0) || (act_cnt_reg >= CNTW'(SLOTS));

    always_comb begin
        case (cmd_reg)
            CMD_CANCEL:     scan_hit = p_act && (ident_rd_reg == tid_reg);
            CMD_CANCEL_ALL: scan_hit = p_act;
            CMD_TICK:       scan_hit = p_act && !(dl_rd_reg > time_reg);
            default:        scan_hit = 1'b0;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        time_next      = time_reg;
        tid_next       = tid_reg;
        tag_next       = tag_reg;
        lfsr_next      = lfsr_reg;
        tries_next     = tries_reg;
        free_cnt_next  = free_cnt_reg;
        act_cnt_next   = act_cnt_reg;
        active_next    = active_reg;
        id_vld_next    = id_vld_reg;
        rd_idx_next    = rd_idx_reg;
        p_idx_next     = p_idx_reg;
        pv_next        = pv_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_out_id_next  = m_out_id_reg;
        m_out_tag_next = m_out_tag_reg;
        m_last_next    = m_last_reg;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        stk_ctrl       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                // Keep the top of the free stack ready for a schedule.
                stk_ctrl.rd_en = 1'b1;
                if (s_valid) begin
                    cmd_next    = s_command;
                    time_next   = s_time_value;
                    tid_next    = s_timer_id;
                    tag_next    = s_handler_tag;
                    rd_idx_next = '0;
                    pv_next     = 1'b0;
                    if (s_command != CMD_SCHEDULE) begin
                        state_next = ST_SCAN;
                    end else if (table_full) begin
                        state_next = ST_FULL;
                    end else begin
                        lfsr_next  = lfsr_step(lfsr_reg);
                        tries_next = '0;
                        state_next = ST_IDSCAN;
                    end
                end
            end
            ST_FULL: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = KIND_FULL;
                    m_out_id_next  = '0;
                    m_out_tag_next = '0;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDSCAN: begin
                if (pv_reg && hit_id) begin
                    pv_next = 1'b0;
                    if (tries_reg < TRW'(SLOTS + 1)) begin
                        // Id collides with a stored one: draw again and rescan.
                        lfsr_next   = lfsr_step(lfsr_reg);
                        tries_next  = tries_reg + TRW'(1);
                        rd_idx_next = '0;
                    end else begin
                        state_next = ST_COMMIT;
                    end
                end else if (scan_end) begin
                    state_next = ST_COMMIT;
                end else if (rd_idx_reg < CNTW'(SLOTS)) begin
                    rd_en       = 1'b1;
                    pv_next     = 1'b1;
                    p_idx_next  = rd_idx_reg[IDXW-1:0];
                    rd_idx_next = rd_idx_reg + CNTW'(1);
                end else begin
                    pv_next = 1'b0;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    mem_we                = 1'b1;
                    stk_ctrl.pop          = 1'b1;
                    free_cnt_next         = free_cnt_reg - CNTW'(1);
                    act_cnt_next          = act_cnt_reg + CNTW'(1);
                    active_next[top_slot] = 1'b1;
                    id_vld_next[top_slot] = 1'b1;
                    m_valid_next          = 1'b1;
                    m_kind_next           = KIND_SCHEDULED;
                    m_out_id_next         = lfsr_reg;
                    m_out_tag_next        = '0;
                    m_last_next           = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DONE;
                end else if (!(pv_reg && scan_hit && (cmd_reg == CMD_TICK) && !out_free)) begin
                    if (pv_reg && scan_hit) begin
                        active_next[p_idx_reg] = 1'b0;
                        if (act_cnt_reg != '0) begin
                            act_cnt_next = act_cnt_reg - CNTW'(1);
                        end
                        if (free_cnt_reg < CNTW'(SLOTS)) begin
                            stk_ctrl.push = 1'b1;
                            free_cnt_next = free_cnt_reg + CNTW'(1);
                        end
                        if (cmd_reg == CMD_TICK) begin
                            m_valid_next   = 1'b1;
                            m_kind_next    = KIND_FIRED;
                            m_out_id_next  = ident_rd_reg;
                            m_out_tag_next = tag_rd_reg;
                            m_last_next    = 1'b0;
                        end
                    end
                    if (rd_idx_reg < CNTW'(SLOTS)) begin
                        rd_en       = 1'b1;
                        pv_next     = 1'b1;
                        p_idx_next  = rd_idx_reg[IDXW-1:0];
                        rd_idx_next = rd_idx_reg + CNTW'(1);
                    end else begin
                        pv_next = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = (cmd_reg == CMD_TICK) ? KIND_TICK_DONE : KIND_CANCEL_DONE;
                    m_out_id_next  = '0;
                    m_out_tag_next = '0;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lfsr_reg     <= LFSR_SEED;
            tries_reg    <= '0;
            free_cnt_reg <= CNTW'(SLOTS);
            act_cnt_reg  <= '0;
            active_reg   <= '0;
            id_vld_reg   <= '0;
            rd_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            lfsr_reg     <= lfsr_next;
            tries_reg    <= tries_next;
            free_cnt_reg <= free_cnt_next;
            act_cnt_reg  <= act_cnt_next;
            active_reg   <= active_next;
            id_vld_reg   <= id_vld_next;
            rd_idx_reg   <= rd_idx_next;
            pv_reg       <= pv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        time_reg      <= time_next;
        tid_reg       <= tid_next;
        tag_reg       <= tag_next;
        p_idx_reg     <= p_idx_next;
        m_kind_reg    <= m_kind_next;
        m_out_id_reg  <= m_out_id_next;
        m_out_tag_reg <= m_out_tag_next;
        m_last_reg    <= m_last_next;
    end

    // Slot memories: one write port for schedule, one registered read for scans.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ident_mem[top_slot] <= lfsr_reg;
            dl_mem[top_slot]    <= time_reg;
            tag_mem[top_slot]   <= tag_reg;
        end
        if (rd_en) begin
            ident_rd_reg <= ident_mem[rd_idx_reg[IDXW-1:0]];
            dl_rd_reg    <= dl_mem[rd_idx_reg[IDXW-1:0]];
            tag_rd_reg   <= tag_mem[rd_idx_reg[IDXW-1:0]];
        end
    end

endmodule
